// ===== rtl/mtrb_pkg.sv =====
// ============================================================================
// mtrb_pkg
// Shared types and constants for the Modbus TCP request builder: command and
// result payloads, the classified frame descriptor, area and function codes.
// ============================================================================
package mtrb_pkg;

   // Frame geometry
   localparam int unsigned FrameBytes = 12;
   localparam int unsigned IdxWidth   = $clog2(FrameBytes);
   localparam logic [IdxWidth-1:0] IdxLast = IdxWidth'(FrameBytes - 1);

   // Byte positions with fixed meaning
   localparam logic [IdxWidth-1:0] IdxLen      = IdxWidth'(5);
   localparam logic [IdxWidth-1:0] IdxUnit     = IdxWidth'(6);
   localparam logic [IdxWidth-1:0] IdxFunc     = IdxWidth'(7);
   localparam logic [IdxWidth-1:0] IdxAddrHi   = IdxWidth'(8);
   localparam logic [IdxWidth-1:0] IdxAddrLo   = IdxWidth'(9);
   localparam logic [IdxWidth-1:0] IdxWordHi   = IdxWidth'(10);
   localparam logic [IdxWidth-1:0] IdxWordLo   = IdxWidth'(11);

   // Header length field (unit id + PDU)
   localparam logic [7:0] HdrLength = 8'd6;

   // Command kinds
   localparam logic KindRead  = 1'b0;
   localparam logic KindWrite = 1'b1;

   // Data areas
   localparam logic [2:0] AreaCoils     = 3'd0;
   localparam logic [2:0] AreaDiscrete  = 3'd1;
   localparam logic [2:0] AreaInputReg  = 3'd2;
   localparam logic [2:0] AreaHoldReg   = 3'd3;
   localparam logic [2:0] AreaInputBits = 3'd4;
   localparam logic [2:0] AreaHoldBits  = 3'd5;

   // Function codes
   localparam logic [7:0] FcReadCoils    = 8'd1;
   localparam logic [7:0] FcReadDiscrete = 8'd2;
   localparam logic [7:0] FcReadHolding  = 8'd3;
   localparam logic [7:0] FcReadInput    = 8'd4;
   localparam logic [7:0] FcWriteCoil    = 8'd5;
   localparam logic [7:0] FcWriteReg     = 8'd6;

   // Write encoding and reply lengths
   localparam logic [15:0] CoilOnValue  = 16'hff00;
   localparam logic [8:0]  ReplyWrite   = 9'd12;
   localparam logic [8:0]  ReplyBitBase = 9'd10;
   localparam logic [8:0]  ReplyRegBase = 9'd9;

   // Status codes
   localparam logic StatusOk    = 1'b0;
   localparam logic StatusUnsup = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  unit_id;
      logic [2:0]  area;
      logic [15:0] start_address;
      logic [3:0]  bit_offset;
      logic [7:0]  length;
      logic [15:0] write_value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
      logic [8:0] expected_response_length;
      logic       status;
   } rsp_type;

   // Classified command, ready to serialize
   typedef struct packed {
      logic        unsup;
      logic [7:0]  unit_id;
      logic [7:0]  func;
      logic [15:0] zaddr;
      logic [15:0] word;
      logic [8:0]  reply;
   } desc_type;

   // Queue status seen by the front and back ends
   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

endpackage

// ===== rtl/modbus_tcp_request_builder.sv =====
// ============================================================================
// modbus_tcp_request_builder
// Builds 12-byte Modbus TCP read and single-write request frames.
// ============================================================================
//
//   channel   ports                     handshake
//   -------   -----------------------   ----------------------------------
//   command   start, busy, req_data     transfer when start && !busy
//   result    rsp_strobe, rsp_data      one cycle per result, no backpressure
//
// A valid command gives twelve results on consecutive cycles; an unsupported
// one gives a single flagged result. The serializer sends one byte per cycle,
// so each valid command holds it for twelve bytes, set by the byte index counter.
// Each command passes the front stage, the queue and the serializer's descriptor and result registers.
// Reset is synchronous and empties the front stage, queue and serializer.
// busy rises only while the front stage holds a command and the queue is full.
module modbus_tcp_request_builder (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mtrb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mtrb_pkg::rsp_type rsp_data
);
   import mtrb_pkg::*;

   logic      push;
   logic      pop;
   desc_type  push_desc;
   desc_type  head_desc;
   qstat_type qstat;

   mtrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_desc (push_desc)
   );

   mtrb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_desc),
      .pop   (pop),
      .rdata (head_desc),
      .qstat (qstat)
   );

   mtrb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc       (head_desc),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // An unsupported result is always a lone, final result
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == StatusUnsup |-> rsp_data.last)
      else $error("unsupported result not marked last");

   // Frame bytes go out back to back until the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside a frame");

   // Reply length appears only with the final byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> rsp_data.expected_response_length == 9'd0)
      else $error("reply length before last byte");

endmodule

// ===== rtl/mtrb_front.sv =====
// ============================================================================
// mtrb_front
// Command front end: takes a command, classifies it into a frame descriptor
// and holds it in one register stage until the queue takes it.
// ============================================================================
module mtrb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mtrb_pkg::req_type  req_data,
   input  mtrb_pkg::qstat_type qstat,
   output logic               push,
   output mtrb_pkg::desc_type push_desc
);
   import mtrb_pkg::*;

   logic     front_valid_ff, front_valid_in;
   desc_type front_desc_ff, front_desc_in;
   logic     take;
   logic [8:0] bit_sum;
   logic [4:0] bit_words;

   // Hold off commands while the stage is full and the queue cannot drain it
   assign push  = front_valid_ff && !qstat.full;
   assign busy  = front_valid_ff && qstat.full;
   assign take  = start && !busy;
   assign push_desc = front_desc_ff;

   assign bit_sum   = {1'b0, req_data.length} + {5'b0, req_data.bit_offset};
   assign bit_words = 5'(bit_sum[8:4]) + 5'd1;

   // Classify the command
   always_comb begin
      front_desc_in         = '0;
      front_desc_in.unit_id = req_data.unit_id;
      front_desc_in.zaddr   = req_data.start_address - 16'd1;
      if (req_data.kind == KindRead) begin
         case (req_data.area)
            AreaCoils, AreaDiscrete: begin
               front_desc_in.func = (req_data.area == AreaCoils) ? FcReadCoils
                                                                 : FcReadDiscrete;
               front_desc_in.word = {8'b0, req_data.length};
               if (req_data.length == 8'd0) begin
                  front_desc_in.reply = ReplyBitBase;
               end else begin
                  front_desc_in.reply = ReplyBitBase
                                      + {4'b0, 5'((req_data.length - 8'd1) >> 3)};
               end
            end
            AreaInputReg, AreaHoldReg: begin
               front_desc_in.func = (req_data.area == AreaInputReg) ? FcReadInput
                                                                    : FcReadHolding;
               front_desc_in.word  = {9'b0, req_data.length[7:1]};
               front_desc_in.reply = {1'b0, req_data.length} + ReplyRegBase;
            end
            AreaInputBits, AreaHoldBits: begin
               front_desc_in.func = (req_data.area == AreaInputBits) ? FcReadInput
                                                                     : FcReadHolding;
               front_desc_in.word  = {11'b0, bit_words};
               front_desc_in.reply = {3'b0, bit_words, 1'b0} + ReplyRegBase;
            end
            default: begin
               front_desc_in.unsup = 1'b1;
            end
         endcase
      end else if (req_data.area == AreaCoils && req_data.length == 8'd1) begin
         front_desc_in.func  = FcWriteCoil;
         front_desc_in.word  = req_data.write_value[0] ? CoilOnValue : 16'h0000;
         front_desc_in.reply = ReplyWrite;
      end else if (req_data.area == AreaHoldReg && req_data.length == 8'd2) begin
         front_desc_in.func  = FcWriteReg;
         front_desc_in.word  = req_data.write_value;
         front_desc_in.reply = ReplyWrite;
      end else begin
         front_desc_in.unsup = 1'b1;
      end
   end

   assign front_valid_in = take || (front_valid_ff && !push);

   // Hold the classified command
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         front_desc_ff <= front_desc_in;
      end
   end

endmodule

// ===== rtl/mtrb_queue.sv =====
// ============================================================================
// mtrb_queue
// Two-entry descriptor queue between the front end and the serializer.
// ============================================================================
module mtrb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mtrb_pkg::desc_type  wdata,
   input  logic                pop,
   output mtrb_pkg::desc_type  rdata,
   output mtrb_pkg::qstat_type qstat
);
   import mtrb_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign qstat.full     = (count_ff == 2'd2);
   assign qstat.nonempty = (count_ff != 2'd0);
   assign rdata          = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/mtrb_back.sv =====
// ============================================================================
// mtrb_back
// Frame serializer: pulls descriptors from the queue and sends one frame byte
// per cycle, or a single flagged result for an unsupported command.
// ============================================================================
module mtrb_back (
   input  logic                clock,
   input  logic                reset,
   input  mtrb_pkg::desc_type  desc,
   input  mtrb_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_strobe,
   output mtrb_pkg::rsp_type   rsp_data
);
   import mtrb_pkg::*;

   logic                active_ff, active_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   desc_type            cur_ff;
   logic                done;
   logic                rsp_strobe_ff;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [7:0]          byte_sel;

   assign done = active_ff && (cur_ff.unsup || idx_ff == IdxLast);
   assign pop  = qstat.nonempty && (!active_ff || done);

   // Advance the byte index
   always_comb begin
      active_in = pop || (active_ff && !done);
      if (pop) begin
         idx_in = '0;
      end else if (active_ff && !done) begin
         idx_in = idx_ff + IdxWidth'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // Select the current frame byte
   always_comb begin
      case (idx_ff)
         IdxLen:    byte_sel = HdrLength;
         IdxUnit:   byte_sel = cur_ff.unit_id;
         IdxFunc:   byte_sel = cur_ff.func;
         IdxAddrHi: byte_sel = cur_ff.zaddr[15:8];
         IdxAddrLo: byte_sel = cur_ff.zaddr[7:0];
         IdxWordHi: byte_sel = cur_ff.word[15:8];
         IdxWordLo: byte_sel = cur_ff.word[7:0];
         default:   byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      rsp_data_in = '0;
      if (cur_ff.unsup) begin
         rsp_data_in.last   = 1'b1;
         rsp_data_in.status = StatusUnsup;
      end else begin
         rsp_data_in.frame_byte = byte_sel;
         rsp_data_in.last       = (idx_ff == IdxLast);
         rsp_data_in.status     = StatusOk;
         if (idx_ff == IdxLast) begin
            rsp_data_in.expected_response_length = cur_ff.reply;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= active_ff;
      end
   end

   // Load the next descriptor and register the result
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= desc;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
